// ===== design/kvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvc_pkg
// shared types and constants for the keyed vigenere cipher
// ----------------------------------------------------------------------------
package kvc_pkg;

    localparam int ALPHA       = 26;
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;
    localparam logic [7:0] LETTER_A = 8'd65;
    localparam logic [7:0] LETTER_Z = 8'd90;

    typedef logic [4:0] t_letter;

    typedef enum logic [2:0] {
        REG_KEY_LOW  = 3'd0,
        REG_KEY_MID  = 3'd1,
        REG_KEY_HIGH = 3'd2,
        REG_KEY_LEN  = 3'd3,
        REG_DIR      = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       key_error;
    } t_out_item;

    typedef struct packed {
        logic [59:0] key_letters_low;
        logic [59:0] key_letters_mid;
        logic [9:0]  key_letters_high;
        logic [4:0]  key_length;
        logic        direction;
    } t_cfg;

    typedef struct packed {
        t_letter [ALPHA-1:0] mixed;
        t_letter [ALPHA-1:0] inv;
        logic                invalid;
    } t_alpha_tab;

endpackage

// ===== design/kvc_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvc_regs
// apb register file holding the key letters, key length and direction
// ----------------------------------------------------------------------------
module kvc_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [kvc_pkg::ADDR_W-1:0] paddr,
    input  logic [kvc_pkg::DATA_W-1:0] pwdata,
    output logic [kvc_pkg::DATA_W-1:0] prdata,
    output logic                  pready,
    output kvc_pkg::t_cfg         o_cfg
);
    import kvc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_letters_low  <= '0;
            r_cfg.key_letters_mid  <= '0;
            r_cfg.key_letters_high <= '0;
            r_cfg.key_length       <= 5'd1;
            r_cfg.direction        <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                REG_KEY_LOW:  r_cfg.key_letters_low  <= pwdata[59:0];
                REG_KEY_MID:  r_cfg.key_letters_mid  <= pwdata[59:0];
                REG_KEY_HIGH: r_cfg.key_letters_high <= pwdata[9:0];
                REG_KEY_LEN:  r_cfg.key_length       <= pwdata[4:0];
                REG_DIR:      r_cfg.direction        <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_KEY_LOW:  prdata = {4'd0, r_cfg.key_letters_low};
            REG_KEY_MID:  prdata = {4'd0, r_cfg.key_letters_mid};
            REG_KEY_HIGH: prdata = {54'd0, r_cfg.key_letters_high};
            REG_KEY_LEN:  prdata = {59'd0, r_cfg.key_length};
            REG_DIR:      prdata = {63'd0, r_cfg.direction};
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== design/kvc_alpha_build.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvc_alpha_build
// builds the mixed alphabet and its inverse from the key registers
// ----------------------------------------------------------------------------
module kvc_alpha_build (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kvc_pkg::t_cfg       i_cfg,
    output kvc_pkg::t_alpha_tab o_tab
);
    import kvc_pkg::*;

    t_alpha_tab           r_tab;
    t_alpha_tab           n_tab;
    t_letter [ALPHA-1:0]  codes;
    logic    [ALPHA-1:0]  in_key;
    logic    [ALPHA-1:0]  used;
    logic    [ALPHA-1:0]  below;
    logic                 len_ok;
    logic                 bad;
    t_letter              key_idx;
    t_letter              rank;
    t_letter              slot;

    assign o_tab = r_tab;

    always_comb begin
        for (int i = 0; i < ALPHA; i++) begin
            if (i < 12) begin
                codes[i] = i_cfg.key_letters_low[5*i +: 5];
            end else if (i < 24) begin
                codes[i] = i_cfg.key_letters_mid[5*(i-12) +: 5];
            end else begin
                codes[i] = i_cfg.key_letters_high[5*(i-24) +: 5];
            end
            in_key[i] = 5'(i) < i_cfg.key_length;
        end

        len_ok = (i_cfg.key_length != 5'd0) && (i_cfg.key_length <= 5'(ALPHA));

        // out-of-range letters and pairwise duplicates
        bad = 1'b0;
        for (int i = 0; i < ALPHA; i++) begin
            if (in_key[i] && codes[i] >= 5'(ALPHA)) begin
                bad = 1'b1;
            end
            for (int j = 0; j < i; j++) begin
                if (in_key[i] && codes[i] == codes[j]) begin
                    bad = 1'b1;
                end
            end
        end

        for (int c = 0; c < ALPHA; c++) begin
            used[c] = 1'b0;
            for (int i = 0; i < ALPHA; i++) begin
                if (in_key[i] && codes[i] == 5'(c)) begin
                    used[c] = 1'b1;
                end
            end
        end

        n_tab.invalid = !len_ok || bad;

        // inverse: key letters take their key index, fillers follow in order
        for (int c = 0; c < ALPHA; c++) begin
            key_idx = '0;
            for (int i = 0; i < ALPHA; i++) begin
                if (in_key[i] && codes[i] == 5'(c)) begin
                    key_idx = key_idx | 5'(i);
                end
            end
            for (int j = 0; j < ALPHA; j++) begin
                below[j] = (j < c) && !used[j];
            end
            rank = 5'($countones(below));
            if (n_tab.invalid) begin
                n_tab.inv[c] = 5'(c);
            end else if (used[c]) begin
                n_tab.inv[c] = key_idx;
            end else begin
                n_tab.inv[c] = i_cfg.key_length + rank;
            end
        end

        for (int n = 0; n < ALPHA; n++) begin
            slot = '0;
            for (int c = 0; c < ALPHA; c++) begin
                if (!used[c] && n_tab.inv[c] == 5'(n)) begin
                    slot = slot | 5'(c);
                end
            end
            if (n_tab.invalid) begin
                n_tab.mixed[n] = 5'(n);
            end else if (in_key[n]) begin
                n_tab.mixed[n] = codes[n];
            end else begin
                n_tab.mixed[n] = slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < ALPHA; n++) begin
                r_tab.mixed[n] <= 5'(n);
                r_tab.inv[n]   <= 5'(n);
            end
            r_tab.invalid <= 1'b0;
        end else begin
            r_tab <= n_tab;
        end
    end

endmodule

// ===== design/kvc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvc_core
// input register, per-byte substitution and result register
// ----------------------------------------------------------------------------
module kvc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kvc_pkg::t_cfg       i_cfg,
    input  kvc_pkg::t_alpha_tab i_cand,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kvc_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kvc_pkg::t_out_item  o_out
);
    import kvc_pkg::*;

    logic       r_s1_valid;
    t_in_item   r_s1;
    logic       r_out_valid;
    t_out_item  r_out;
    t_alpha_tab r_tab;
    t_letter    r_pos;

    t_out_item  n_out;
    t_letter    n_pos;
    t_alpha_tab tab;
    t_letter    pos;
    t_letter    k;
    t_letter    p;
    t_letter    code;
    logic [5:0] sum;
    logic [5:0] diff;
    logic [5:0] nxt;
    logic       is_letter;
    logic       out_free;
    logic       s1_move;

    assign out_free    = !r_out_valid || i_out_ready;
    assign s1_move     = r_s1_valid && out_free;
    assign o_in_ready  = !r_s1_valid || s1_move;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        tab       = r_s1.message_start ? i_cand : r_tab;
        pos       = r_s1.message_start ? 5'd0 : r_pos;
        k         = tab.mixed[pos];
        is_letter = (r_s1.data_byte >= LETTER_A) && (r_s1.data_byte <= LETTER_Z);
        p         = 5'(r_s1.data_byte - LETTER_A);

        sum = {1'b0, p} + {1'b0, k};
        if (sum >= 6'(ALPHA)) begin
            sum = sum - 6'(ALPHA);
        end
        diff = {1'b0, tab.inv[p]} + 6'(ALPHA) - {1'b0, k};
        if (diff >= 6'(ALPHA)) begin
            diff = diff - 6'(ALPHA);
        end

        if (i_cfg.direction) begin
            code = diff[4:0];
        end else begin
            code = tab.mixed[sum[4:0]];
        end

        if (!tab.invalid && is_letter) begin
            n_out.result_byte = LETTER_A + {3'd0, code};
        end else begin
            n_out.result_byte = r_s1.data_byte;
        end
        n_out.key_error = tab.invalid;

        nxt = {1'b0, pos} + 6'd1;
        if (nxt >= {1'b0, i_cfg.key_length} || nxt >= 6'(ALPHA)) begin
            nxt = '0;
        end
        n_pos = nxt[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            for (int n = 0; n < ALPHA; n++) begin
                r_tab.mixed[n] <= 5'(n);
                r_tab.inv[n]   <= 5'(n);
            end
            r_tab.invalid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_move) begin
                r_pos <= n_pos;
                r_tab <= tab;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < 5'(ALPHA))
        else $error("key position out of range");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_error_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && tab.invalid |=> r_out.key_error
            && r_out.result_byte == $past(r_s1.data_byte))
        else $error("invalid key did not pass data through");

    a_letter_stays_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && is_letter |=> r_out.result_byte >= LETTER_A
            && r_out.result_byte <= LETTER_Z)
        else $error("letter mapped outside the alphabet");
`endif

endmodule

// ===== design/keyed_vigenere_cipher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_vigenere_cipher_top
// keyword-mixed vigenere cipher over an ascii byte stream
// ----------------------------------------------------------------------------
// bytes enter on i_in (valid/ready) and leave on o_out (valid/ready), one
// result per byte. message_start restarts the key position and latches the
// alphabet built from the current key registers.
// a byte passes from the input register through the single substitution stage
// into the result register; one byte is taken every cycle while the receiver
// takes results.
// the key alphabet is rebuilt into a register from the key registers after any
// apb write, so a byte may follow a configuration write straight away.
// when the receiver stalls the result register holds, the input register
// still takes one byte, then ready drops until the result is taken.
// reset clears both stages, the key position, and sets the key to "A",
// key length 1, encode.
// registers lie at byte address 8*i: key letters low, mid, high, key length,
// direction.
// ----------------------------------------------------------------------------
module keyed_vigenere_cipher_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kvc_pkg::ADDR_W-1:0] paddr,
    input  logic [kvc_pkg::DATA_W-1:0] pwdata,
    output logic [kvc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  kvc_pkg::t_in_item          i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output kvc_pkg::t_out_item         o_out
);
    import kvc_pkg::*;

    t_cfg       cfg;
    t_alpha_tab cand;

    kvc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    kvc_alpha_build u_build (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .o_tab   (cand)
    );

    kvc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cand      (cand),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the keyed vigenere cipher
// ----------------------------------------------------------------------------
// keys are loaded over apb while the block is idle. A short directed run
// covers the reset key, both directions, the full-length key, invalid keys and
// a key length change in the middle of a message. Random phases follow:
// mostly well-formed keys with letter-heavy messages, some broken keys and
// some length changes without a message start. A scoreboard keeps its own
// copy of the alphabet and key position, predicts each result and compares it
// with the result transfers. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import kvc_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int RANDOM_ITEMS = 800;
    localparam logic [7:0] BORDER_BYTES [8] = '{8'h40, 8'h41, 8'h5A, 8'h5B,
                                                8'h60, 8'h61, 8'h7A, 8'h7B};

    typedef t_letter t_key [ALPHA];

    class cipher_scoreboard;
        logic [59:0] key_low;
        logic [59:0] key_mid;
        logic [9:0]  key_high;
        logic [4:0]  key_len;
        logic        decode;
        int          position;
        t_letter     mixed [ALPHA];
        logic        invalid;
        t_out_item   expected_q [$];
        int          errors;

        function new();
            key_low  = '0;
            key_mid  = '0;
            key_high = '0;
            key_len  = 5'd1;
            decode   = 1'b0;
            position = 0;
            errors   = 0;
            rebuild_alphabet();
        endfunction

        function void write_reg(t_reg_idx idx, logic [63:0] value);
            case (idx)
                REG_KEY_LOW:  key_low  = value[59:0];
                REG_KEY_MID:  key_mid  = value[59:0];
                REG_KEY_HIGH: key_high = value[9:0];
                REG_KEY_LEN:  key_len  = value[4:0];
                REG_DIR:      decode   = value[0];
                default: ;
            endcase
        endfunction

        function t_letter key_code(int i);
            if (i < 12) return key_low[5*i +: 5];
            if (i < 24) return key_mid[5*(i-12) +: 5];
            return key_high[5*(i-24) +: 5];
        endfunction

        function void rebuild_alphabet();
            bit      used [ALPHA];
            int      n;
            t_letter c;
            n = 0;
            foreach (used[i]) used[i] = 1'b0;
            invalid = (key_len == 0 || key_len > ALPHA);
            if (!invalid) begin
                for (int i = 0; i < key_len; i++) begin
                    c = key_code(i);
                    if (c >= ALPHA || used[c]) begin
                        invalid = 1'b1;
                        break;
                    end
                    used[c] = 1'b1;
                    mixed[n] = c;
                    n++;
                end
            end
            if (invalid) begin
                foreach (used[i]) used[i] = 1'b0;
                n = 0;
            end
            for (int i = 0; i < ALPHA && n < ALPHA; i++) begin
                if (!used[i]) begin
                    used[i] = 1'b1;
                    mixed[n] = t_letter'(i);
                    n++;
                end
            end
        endfunction

        function void note_input(t_in_item item);
            t_out_item want;
            int        k;
            int        p;
            int        pos;
            if (item.message_start) begin
                position = 0;
                rebuild_alphabet();
            end
            if (position >= ALPHA) position = 0;
            want.result_byte = item.data_byte;
            want.key_error   = invalid;
            if (!invalid && item.data_byte >= LETTER_A && item.data_byte <= LETTER_Z) begin
                k = mixed[position];
                p = item.data_byte - LETTER_A;
                if (!decode) begin
                    want.result_byte = LETTER_A + 8'(mixed[(p + k) % ALPHA]);
                end else begin
                    pos = 0;
                    for (int i = 0; i < ALPHA; i++) begin
                        if (mixed[i] == p) pos = i;
                    end
                    want.result_byte = LETTER_A + 8'((pos + ALPHA - k) % ALPHA);
                end
            end
            position++;
            if (position >= key_len || position >= ALPHA) position = 0;
            expected_q.push_back(want);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result byte %02h key_error %0b",
                               got.result_byte, got.key_error));
                return;
            end
            want = expected_q.pop_front();
            if (got.result_byte !== want.result_byte || got.key_error !== want.key_error)
                flag($sformatf("byte %02h key_error %0b, expected byte %02h key_error %0b",
                               got.result_byte, got.key_error,
                               want.result_byte, want.key_error));
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_item          i_in;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_item         o_out;
    logic              steady = 1'b0;
    int                cycles = 0;
    cipher_scoreboard  sb = new();

    keyed_vigenere_cipher_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_input(i_in);
            if (o_out_valid && i_out_ready) sb.check_result(o_out);
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_in_item byte_item(logic [7:0] data, logic start);
        t_in_item item;
        item.data_byte     = data;
        item.message_start = start;
        return item;
    endfunction

    function automatic t_key from_word(string word);
        t_key letters;
        foreach (letters[i]) letters[i] = '0;
        for (int i = 0; i < word.len(); i++) letters[i] = t_letter'(word[i] - LETTER_A);
        return letters;
    endfunction

    task automatic write_register(t_reg_idx idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic load_key(t_key letters, int len);
        logic [59:0] low;
        logic [59:0] mid;
        logic [9:0]  high;
        for (int i = 0; i < 12; i++) begin
            low[5*i +: 5] = letters[i];
            mid[5*i +: 5] = letters[12+i];
        end
        high = {letters[25], letters[24]};
        write_register(REG_KEY_LOW, 64'(low));
        write_register(REG_KEY_MID, 64'(mid));
        write_register(REG_KEY_HIGH, 64'(high));
        write_register(REG_KEY_LEN, 64'(len));
    endtask

    task automatic send_items(t_in_item items [$]);
        int gap;
        foreach (items[i]) begin
            gap = pick_gap();
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in       <= items[i];
            i_in_valid <= 1'b1;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : result_side
        int stall;
        i_out_ready <= 1'b1;
        forever begin
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_in_item    q [$];
        t_key        letters;
        t_letter     tmp;
        int          len;
        int          j;
        int          r;
        int          kind;
        int          count;
        int          sent;
        logic [7:0]  data;
        bit          carry_on;

        sent = 0;
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key is a single A: letters map to themselves
        q = '{byte_item("A", 1'b0), byte_item("Z", 1'b0), byte_item(8'h40, 1'b1),
              byte_item(8'hFF, 1'b0)};
        send_items(q);
        wait_idle();

        load_key(from_word("KEYWORD"), 7);
        write_register(REG_DIR, 64'd0);
        q = '{byte_item("A", 1'b1), byte_item("Z", 1'b0), byte_item(8'h5B, 1'b0),
              byte_item(8'h00, 1'b0), byte_item("M", 1'b0), byte_item("Q", 1'b0),
              byte_item("B", 1'b0), byte_item("C", 1'b0)};
        send_items(q);
        wait_idle();

        write_register(REG_DIR, 64'd1);
        q = '{byte_item("A", 1'b1), byte_item("Z", 1'b0), byte_item(8'h40, 1'b0),
              byte_item("K", 1'b0)};
        send_items(q);
        wait_idle();

        // full-length key, reversed alphabet
        foreach (letters[i]) letters[i] = t_letter'(ALPHA - 1 - i);
        load_key(letters, ALPHA);
        write_register(REG_DIR, 64'd0);
        q = '{byte_item("A", 1'b1), byte_item("Z", 1'b0)};
        send_items(q);
        wait_idle();

        // letter codes out of range
        foreach (letters[i]) letters[i] = 5'd31;
        load_key(letters, ALPHA);
        q = '{byte_item("Q", 1'b1), byte_item("A", 1'b0)};
        send_items(q);
        wait_idle();

        load_key(from_word("KEY"), 0);
        q = '{byte_item("B", 1'b1)};
        send_items(q);
        wait_idle();

        write_register(REG_KEY_LEN, 64'd31);
        q = '{byte_item("C", 1'b1)};
        send_items(q);
        wait_idle();

        load_key(from_word("ALPHA"), 5);
        q = '{byte_item("D", 1'b1)};
        send_items(q);
        wait_idle();

        // key length grows mid-message, new letters wait for the next start
        load_key(from_word("CAT"), 3);
        q = '{byte_item("H", 1'b1), byte_item("I", 1'b0)};
        send_items(q);
        wait_idle();
        write_register(REG_KEY_LEN, 64'd10);
        write_register(REG_KEY_LOW, 64'h0FFF_FFFF_FFFF_FFFF);
        q = '{byte_item("E", 1'b0), byte_item("L", 1'b0), byte_item("L", 1'b0),
              byte_item("O", 1'b0)};
        send_items(q);
        wait_idle();

        while (sent < RANDOM_ITEMS) begin
            steady   = ($urandom_range(0, 5) == 0);
            kind     = $urandom_range(0, 99);
            carry_on = (kind >= 85);
            if (!carry_on) begin
                foreach (letters[i]) letters[i] = t_letter'(i);
                for (int i = ALPHA - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = letters[i];
                    letters[i] = letters[j];
                    letters[j] = tmp;
                end
                r = $urandom_range(0, 9);
                len = (r == 0) ? 1 : (r == 1) ? ALPHA : $urandom_range(1, ALPHA);
                for (int i = len; i < ALPHA; i++) letters[i] = t_letter'($urandom_range(0, 31));
                if (kind < 8 && len >= 2) begin
                    j = $urandom_range(1, len - 1);
                    letters[j] = letters[$urandom_range(0, j - 1)];
                end else if (kind >= 8 && kind < 12) begin
                    letters[$urandom_range(0, len - 1)] = t_letter'($urandom_range(ALPHA, 31));
                end else if (kind >= 12 && kind < 15) begin
                    len = $urandom_range(0, 1) ? 0 : $urandom_range(ALPHA + 1, 31);
                end
                load_key(letters, len);
            end else begin
                write_register(REG_KEY_LEN, 64'($urandom_range(1, ALPHA)));
                if ($urandom_range(0, 1))
                    write_register(REG_KEY_LOW, {$urandom(), $urandom()} & 64'h0FFF_FFFF_FFFF_FFFF);
            end
            if ($urandom_range(0, 2) == 0) write_register(REG_DIR, 64'($urandom_range(0, 1)));

            count = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(3, 24);
            q.delete();
            for (int i = 0; i < count; i++) begin
                r = $urandom_range(0, 99);
                if (r < 75) data = 8'($urandom_range(LETTER_A, LETTER_Z));
                else if (r < 85) data = BORDER_BYTES[$urandom_range(0, 7)];
                else data = 8'($urandom_range(0, 255));
                q.push_back(byte_item(data, (i == 0 && !carry_on) || $urandom_range(0, 39) == 0));
            end
            send_items(q);
            sent += count;
            wait_idle();
        end

        steady = 1'b0;
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) sb.flag($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/kvc_pkg.sv
design/kvc_regs.sv
design/kvc_alpha_build.sv
design/kvc_core.sv
design/keyed_vigenere_cipher_top.sv
tb/sv/tb_top.sv
